FILE: rtl/vwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwt_pkg
// Shared types and constants for the vertex weld table.
// ----------------------------------------------------------------------------
package vwt_pkg;

  localparam int XY_W  = 32;
  localparam int IDX_W = 8;
  localparam int TOL_W = 16;
  localparam int CMD_W = 2;
  localparam int STS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_FOUND     = 3'd0,
    STS_ADDED     = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_AMBIGUOUS = 3'd4,
    STS_BAD_INDEX = 3'd5
  } status_t;

  // One compare result leaving the match stage
  typedef struct packed {
    logic valid;
    logic hit;
  } match_t;

endpackage

FILE: rtl/vwt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwt_in_if / vwt_out_if
// Valid/ready channels carrying commands into and results out of the table.
// ----------------------------------------------------------------------------
interface vwt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic [7:0]         entry_index;

  modport source (output valid, command, x_coord, y_coord, entry_index, input ready);
  modport sink   (input valid, command, x_coord, y_coord, entry_index, output ready);
endinterface

interface vwt_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         result_index;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic [2:0]         status;

  modport source (output valid, result_index, result_x, result_y, status, input ready);
  modport sink   (input valid, result_index, result_x, result_y, status, output ready);
endinterface

FILE: rtl/vwt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vwt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/vwt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwt_match
// Two-stage tolerance compare of one stored point against the query point.
// ----------------------------------------------------------------------------
module vwt_match import vwt_pkg::*; #(
  parameter int AW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_valid,
  input  logic [AW-1:0]          rd_idx,
  input  logic signed [XY_W-1:0] stored_x,
  input  logic signed [XY_W-1:0] stored_y,
  input  logic signed [XY_W-1:0] query_x,
  input  logic signed [XY_W-1:0] query_y,
  input  logic [TOL_W-2:0]       half_tol,
  output match_t                 match,
  output logic [AW-1:0]          match_idx
);

  logic signed [XY_W:0] dx_r, dy_r;
  logic signed [XY_W:0] lim;
  logic                 v_r;
  logic [AW-1:0]        idx_r;

  // Differences at full precision, so they never wrap
  always_ff @(posedge clk) begin
    dx_r  <= $signed({stored_x[XY_W-1], stored_x}) - $signed({query_x[XY_W-1], query_x});
    dy_r  <= $signed({stored_y[XY_W-1], stored_y}) - $signed({query_y[XY_W-1], query_y});
    idx_r <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= rd_valid;
    end
  end

  // 2*|d| <= tol  is the same as  |d| <= tol/2 (floor)
  assign lim         = $signed({{(XY_W+2-TOL_W){1'b0}}, half_tol});
  assign match.valid = v_r;
  assign match.hit   = (dx_r <= lim) && (dx_r >= -lim) && (dy_r <= lim) && (dy_r >= -lim);
  assign match_idx   = idx_r;

endmodule

FILE: rtl/vertex_weld_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_weld_table_core
// Vertex deduplication table for Q16.16 points with tolerance matching.
// ----------------------------------------------------------------------------
// One command is handled at a time. Insert and lookup scan the stored points
// through the single read port of the point memory, one entry per cycle, and
// then wait for the RAM read register and the two-stage compare behind it to
// drain. Read location passes through ST_RLOC and ST_RWAIT, and clear goes
// straight to ST_FINISH. A finished result sits in the output register while
// the next command is already accepted. The tolerance register must be
// written only while the table is idle.
module vertex_weld_table_core import vwt_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  vwt_in_if.sink      in_ch,
  vwt_out_if.source   out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RLOC,
    ST_RWAIT,
    ST_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [TOL_W-1:0]      tol_r;
  cmd_t                  cmd_r, cmd_nxt;
  logic signed [XY_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]         issue_r, issue_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [1:0]            hits_r, hits_nxt;
  logic [AW-1:0]         first_r, first_nxt;
  logic [IDX_W-1:0]      res_index_r, res_index_nxt;
  logic signed [XY_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_index_r, out_index_nxt;
  logic signed [XY_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*XY_W-1:0]     ram_wdata, ram_rdata;
  match_t                match;
  logic [AW-1:0]         match_idx;
  logic                  scan_more;
  logic                  idx_ok;

  vwt_ram #(
    .WIDTH (2*XY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vwt_match #(
    .AW (AW)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_v_r),
    .rd_idx    (rd_idx_r),
    .stored_x  (ram_rdata[2*XY_W-1:XY_W]),
    .stored_y  (ram_rdata[XY_W-1:0]),
    .query_x   (qx_r),
    .query_y   (qy_r),
    .half_tol  (tol_r[TOL_W-1:1]),
    .match     (match),
    .match_idx (match_idx)
  );

  assign scan_more = (issue_r < count_r);
  assign idx_ok    = (EW'(idx_r) < EW'(count_r));
  assign ram_wdata = {qx_r, qy_r};
  assign ram_waddr = count_r[AW-1:0];

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.result_x     = out_x_r;
  assign out_ch.result_y     = out_y_r;
  assign out_ch.status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    rd_v_nxt       = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    hits_nxt       = hits_r;
    first_nxt      = first_r;
    res_index_nxt  = res_index_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_index_nxt  = out_index_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_raddr      = issue_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.command);
          qx_nxt    = in_ch.x_coord;
          qy_nxt    = in_ch.y_coord;
          idx_nxt   = in_ch.entry_index;
          issue_nxt = '0;
          hits_nxt  = '0;
          first_nxt = '0;
          case (cmd_t'(in_ch.command))
            CMD_INSERT, CMD_LOOKUP: state_nxt = ST_SCAN;
            CMD_READ:               state_nxt = ST_RLOC;
            default: begin
              count_nxt      = '0;
              res_index_nxt  = '0;
              res_x_nxt      = '0;
              res_y_nxt      = '0;
              res_status_nxt = STS_FOUND;
              state_nxt      = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle until every stored entry is out
        rd_v_nxt   = scan_more;
        rd_idx_nxt = issue_r[AW-1:0];
        if (scan_more) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (match.valid && match.hit) begin
          if (hits_r == 2'd0) begin
            first_nxt = match_idx;
          end
          hits_nxt = (hits_r == 2'd2) ? 2'd2 : hits_r + 2'd1;
        end
        if (!scan_more && !rd_v_r && !match.valid) begin
          res_index_nxt = '0;
          res_x_nxt     = '0;
          res_y_nxt     = '0;
          if (hits_r == 2'd1) begin
            res_index_nxt  = IDX_W'(first_r);
            res_status_nxt = STS_FOUND;
          end else if (hits_r == 2'd2) begin
            res_status_nxt = STS_AMBIGUOUS;
          end else if (cmd_r == CMD_LOOKUP) begin
            res_status_nxt = STS_NOT_FOUND;
          end else if (count_r == CW'(TABLE_DEPTH)) begin
            res_status_nxt = STS_FULL;
          end else begin
            // Append the new point at the next dense index
            ram_we         = 1'b1;
            res_index_nxt  = IDX_W'(count_r);
            res_status_nxt = STS_ADDED;
            count_nxt      = count_r + 1'b1;
          end
          state_nxt = ST_FINISH;
        end
      end

      ST_RLOC: begin
        ram_raddr = AW'(idx_r);
        state_nxt = ST_RWAIT;
      end

      ST_RWAIT: begin
        if (idx_ok) begin
          res_index_nxt  = idx_r;
          res_x_nxt      = ram_rdata[2*XY_W-1:XY_W];
          res_y_nxt      = ram_rdata[XY_W-1:0];
          res_status_nxt = STS_FOUND;
        end else begin
          res_index_nxt  = '0;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          res_status_nxt = STS_BAD_INDEX;
        end
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold until the output register is free or being drained
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = res_index_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tol_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    idx_r        <= idx_nxt;
    issue_r      <= issue_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hits_r       <= hits_nxt;
    first_r      <= first_nxt;
    res_index_r  <= res_index_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_status_r <= res_status_nxt;
    out_index_r  <= out_index_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
